[design/mfsd_pkg.sv]
// ----------------------------------------------------------------------------
// mfsd_pkg
// Shared types, widths and reset values of the marker framed sample deframer.
// ----------------------------------------------------------------------------
package mfsd_pkg;

   localparam int BYTE_WIDTH     = 8;
   localparam int SAMPLE_WIDTH   = 16;
   localparam int LIMIT_WIDTH    = 16;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // Sample sign handling: bit 11 set forces the top nibble to ones
   localparam int SIGN_BIT_POS = 11;
   localparam logic [3:0] SIGN_FILL = 4'hF;

   localparam logic [BYTE_WIDTH-1:0]  START_MARKER_RESET   = 8'hFF;
   localparam logic [BYTE_WIDTH-1:0]  STOP_MARKER_RESET    = 8'h1F;
   localparam logic [LIMIT_WIDTH-1:0] FRAME_LIMIT_RESET    = 16'd20480;
   localparam logic [LIMIT_WIDTH-1:0] EXPECTED_COUNT_RESET = 16'd20479;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_START_MARKER   = 2'd0,
      CSR_STOP_MARKER    = 2'd1,
      CSR_FRAME_LIMIT    = 2'd2,
      CSR_EXPECTED_COUNT = 2'd3
   } csr_index_type;

   typedef enum logic {
      RESULT_SAMPLE    = 1'b0,
      RESULT_FRAME_END = 1'b1
   } result_kind_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0]  start_marker;
      logic [BYTE_WIDTH-1:0]  stop_marker;
      logic [LIMIT_WIDTH-1:0] frame_limit;
      logic [LIMIT_WIDTH-1:0] expected_count;
   } cfg_type;

   typedef struct packed {
      logic                           result_kind;
      logic signed [SAMPLE_WIDTH-1:0] sample_value;
      logic [SAMPLE_WIDTH-1:0]        sample_index;
      logic                           frame_ok;
      logic [SAMPLE_WIDTH-1:0]        frame_count;
   } rsp_payload_type;

   typedef struct packed {
      logic in_frame;
      logic byte_phase;
   } core_status_type;

   typedef struct packed {
      logic main_valid;
      logic skid_valid;
   } buf_status_type;

endpackage

[design/mfsd_stream_if.sv]
// ----------------------------------------------------------------------------
// mfsd_req_if / mfsd_rsp_if
// Valid/ready channels for raw link bytes and for deframed results.
// ----------------------------------------------------------------------------
interface mfsd_req_if;
   import mfsd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface mfsd_rsp_if;
   import mfsd_pkg::*;

   logic                           valid;
   logic                           ready;
   logic                           result_kind;
   logic signed [SAMPLE_WIDTH-1:0] sample_value;
   logic [SAMPLE_WIDTH-1:0]        sample_index;
   logic                           frame_ok;
   logic [SAMPLE_WIDTH-1:0]        frame_count;

   modport source (output valid, output result_kind, output sample_value,
                   output sample_index, output frame_ok, output frame_count,
                   input ready);
   modport sink   (input valid, input result_kind, input sample_value,
                   input sample_index, input frame_ok, input frame_count,
                   output ready);
endinterface

[design/mfsd_csr.sv]
// ----------------------------------------------------------------------------
// mfsd_csr
// Configuration registers, written through a plain index/data write port.
// ----------------------------------------------------------------------------
module mfsd_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [mfsd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [mfsd_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   output mfsd_pkg::cfg_type                      cfg
);
   import mfsd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_START_MARKER:   cfg_in.start_marker   = csr_write_data[BYTE_WIDTH-1:0];
            CSR_STOP_MARKER:    cfg_in.stop_marker    = csr_write_data[BYTE_WIDTH-1:0];
            CSR_FRAME_LIMIT:    cfg_in.frame_limit    = csr_write_data[LIMIT_WIDTH-1:0];
            CSR_EXPECTED_COUNT: cfg_in.expected_count = csr_write_data[LIMIT_WIDTH-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker   <= START_MARKER_RESET;
         cfg_ff.stop_marker    <= STOP_MARKER_RESET;
         cfg_ff.frame_limit    <= FRAME_LIMIT_RESET;
         cfg_ff.expected_count <= EXPECTED_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/mfsd_core.sv]
// ----------------------------------------------------------------------------
// mfsd_core
// Marker detection, byte pairing, sample forming and the sample counter.
// ----------------------------------------------------------------------------
module mfsd_core #(
   parameter int COUNT_WIDTH = mfsd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [mfsd_pkg::BYTE_WIDTH-1:0]   data_byte,
   input  mfsd_pkg::cfg_type                 cfg,
   output logic                              push,
   output mfsd_pkg::rsp_payload_type         payload,
   output mfsd_pkg::core_status_type         status
);
   import mfsd_pkg::*;

   localparam int CMP_WIDTH = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

   logic [BYTE_WIDTH-1:0]  prev_byte_ff, prev_byte_in;
   logic                   in_frame_ff, in_frame_in;
   logic                   phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] counter_ff, counter_in;

   logic [CMP_WIDTH-1:0]    count_ext;
   logic [CMP_WIDTH-1:0]    limit_ext;
   logic [CMP_WIDTH-1:0]    expected_ext;
   logic                    stop_hit;
   logic                    start_hit;
   logic [SAMPLE_WIDTH-1:0] formed;

   assign count_ext    = CMP_WIDTH'(counter_ff);
   assign limit_ext    = CMP_WIDTH'(cfg.frame_limit);
   assign expected_ext = CMP_WIDTH'(cfg.expected_count);

   assign stop_hit  = (data_byte == cfg.stop_marker)  && (prev_byte_ff == cfg.stop_marker);
   assign start_hit = (data_byte == cfg.start_marker) && (prev_byte_ff == cfg.start_marker);

   always_comb begin
      formed = {prev_byte_ff, data_byte};
      if (formed[SIGN_BIT_POS]) begin
         formed[SAMPLE_WIDTH-1 -: 4] = SIGN_FILL;
      end
   end

   always_comb begin
      prev_byte_in = prev_byte_ff;
      in_frame_in  = in_frame_ff;
      phase_in     = phase_ff;
      counter_in   = counter_ff;
      push         = 1'b0;
      payload      = '0;
      if (accept) begin
         prev_byte_in = data_byte;
         if (stop_hit) begin
            push                = 1'b1;
            payload.result_kind = RESULT_FRAME_END;
            payload.frame_ok    = (count_ext == expected_ext);
            payload.frame_count = count_ext[SAMPLE_WIDTH-1:0];
            counter_in          = '0;
            phase_in            = 1'b0;
            in_frame_in         = 1'b0;
         end else if (start_hit) begin
            counter_in  = '0;
            phase_in    = 1'b0;
            in_frame_in = 1'b1;
         end else if (in_frame_ff) begin
            if (phase_ff) begin
               if (count_ext < limit_ext) begin
                  push                 = 1'b1;
                  payload.result_kind  = RESULT_SAMPLE;
                  payload.sample_value = formed;
                  payload.sample_index = count_ext[SAMPLE_WIDTH-1:0];
               end
               // saturate at all ones
               if (!(&counter_ff)) begin
                  counter_in = counter_ff + 1'b1;
               end
            end
            phase_in = ~phase_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_byte_ff <= '0;
         in_frame_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         counter_ff   <= '0;
      end else begin
         prev_byte_ff <= prev_byte_in;
         in_frame_ff  <= in_frame_in;
         phase_ff     <= phase_in;
         counter_ff   <= counter_in;
      end
   end

   assign status.in_frame   = in_frame_ff;
   assign status.byte_phase = phase_ff;

endmodule

[design/mfsd_out_buf.sv]
// ----------------------------------------------------------------------------
// mfsd_out_buf
// Result register with one skid entry; decouples request ready from rsp ready.
// ----------------------------------------------------------------------------
module mfsd_out_buf (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  mfsd_pkg::rsp_payload_type   push_data,
   output logic                        in_ready,
   output logic                        out_valid,
   input  logic                        out_ready,
   output mfsd_pkg::rsp_payload_type   out_data,
   output mfsd_pkg::buf_status_type    status
);
   import mfsd_pkg::*;

   logic            main_valid_ff, main_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type main_ff, main_in;
   rsp_payload_type skid_ff, skid_in;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         // main slot frees up: drain skid first, else take the new result
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign in_ready          = !skid_valid_ff;
   assign out_valid         = main_valid_ff;
   assign out_data          = main_ff;
   assign status.main_valid = main_valid_ff;
   assign status.skid_valid = skid_valid_ff;

endmodule

[design/marker_framed_sample_deframer.sv]
// ----------------------------------------------------------------------------
// marker_framed_sample_deframer
// Recovers frames of 12-bit samples from a byte stream framed by marker pairs.
// One request carries one link byte. The block takes a request in every clock
// cycle while its skid entry is empty and answers it with zero or one result:
// all decoding is one pass of compares and a counter update between the state
// registers and the result register, and a one-entry skid behind the result
// register keeps the request side taking bytes while one result waits on rsp
// ready. Two stop marker bytes in a row emit a frame-end result (count and ok
// flag); two start marker bytes in a row open a frame. Inside a frame, bytes
// pair high then low into samples, emitted with their index while the index is
// below frame_limit. Write configuration only while no request is in flight.
// ----------------------------------------------------------------------------
module marker_framed_sample_deframer #(
   parameter int COUNT_WIDTH = mfsd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   mfsd_req_if.sink                             req_chan,
   mfsd_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [mfsd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mfsd_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import mfsd_pkg::*;

   cfg_type         cfg;
   logic            accept;
   logic            push;
   logic            in_ready;
   rsp_payload_type push_data;
   rsp_payload_type out_data;
   core_status_type core_status;
   buf_status_type  buf_status;

   // Hold configuration registers
   mfsd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Advance framing state on every accepted request
   assign accept       = req_chan.valid && in_ready;
   assign req_chan.ready = in_ready;

   mfsd_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_chan.data_byte),
      .cfg       (cfg),
      .push      (push),
      .payload   (push_data),
      .status    (core_status)
   );

   // Register results; the skid entry absorbs one result under backpressure
   mfsd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .in_ready  (in_ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_data),
      .status    (buf_status)
   );

   assign rsp_chan.result_kind  = out_data.result_kind;
   assign rsp_chan.sample_value = out_data.sample_value;
   assign rsp_chan.sample_index = out_data.sample_index;
   assign rsp_chan.frame_ok     = out_data.frame_ok;
   assign rsp_chan.frame_count  = out_data.frame_count;

`ifndef SYNTHESIS
   // A skid entry is only ever filled behind a full result register
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      buf_status.skid_valid |-> buf_status.main_valid)
      else $error("skid entry valid while result register empty");

   // The response side is valid in the cycle after every produced result
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_chan.valid)
      else $error("produced result not presented");

   // A frame end always closes the frame and realigns byte pairing
   a_frame_end_closes: assert property (@(posedge clock) disable iff (reset)
      (push && push_data.result_kind == RESULT_FRAME_END)
         |=> (!core_status.in_frame && !core_status.byte_phase))
      else $error("frame still open after frame end");

   // A full skid entry must stall the request side
   a_stall_on_skid: assert property (@(posedge clock) disable iff (reset)
      buf_status.skid_valid |-> !req_chan.ready)
      else $error("request taken while skid entry full");
`endif

endmodule
